FILE: sv/sha_pkg.sv
package sha_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_PAD,
		ST_ROUND,
		ST_FOLD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic       init;
		logic       push;
		logic [1:0] push_sel;
		logic       start;
		logic       round;
		logic       fold;
		logic       add_len;
		logic [2:0] add_bytes;
	} dp_cmd_t;

	typedef struct packed {
		logic [3:0] word_cnt;
		logic [5:0] round_cnt;
	} dp_stat_t;

	localparam logic [1:0] SEL_DATA = 2'd0;
	localparam logic [1:0] SEL_PART = 2'd1;
	localparam logic [1:0] SEL_ZERO = 2'd2;
	localparam logic [1:0] SEL_LEN  = 2'd3;

	localparam logic [31:0] PAD_WORD = 32'h8000_0000;

	localparam logic [255:0] INIT_HASH = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic logic [31:0] round_k(input logic [5:0] r);
		logic [31:0] k;
		case (r)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			6'd63: k = 32'hc67178f2;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

endpackage

FILE: sv/sha_dp.sv
module sha_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  sha_pkg::dp_cmd_t cmd,
	output sha_pkg::dp_stat_t stat,
	input  logic [31:0]      data_word,
	input  logic [2:0]       part_bytes,
	input  logic [2:0]       emit_idx,
	output logic [31:0]      digest_out
);
	import sha_pkg::*;

	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [3:0]  wcnt_q;
	logic [5:0]  rcnt_q;
	logic [63:0] len_q;

	logic [31:0] push_word, keep, wt, x15, x2, s0, s1, big0, big1, chs, mj, t1;
	logic [63:0] len_next;

	assign len_next = len_q + {58'd0, cmd.add_bytes, 3'd0};

	always_comb begin
		keep = (part_bytes == 3'd0) ? 32'h0 : (32'hffff_ffff << (6'd32 - {part_bytes, 3'd0}));
		case (cmd.push_sel)
			SEL_DATA: push_word = data_word;
			SEL_PART: push_word = (data_word & keep) | (PAD_WORD >> {part_bytes, 3'd0});
			SEL_ZERO: push_word = 32'h0;
			SEL_LEN:  push_word = (wcnt_q == 4'd14) ? len_q[63:32] : len_q[31:0];
			default:  push_word = 32'h0;
		endcase
	end

	// window slot w_q[r & 15] holds w[r-16] at round r
	always_comb begin
		x15  = w_q[4'(rcnt_q + 6'd1)];
		x2   = w_q[4'(rcnt_q + 6'd14)];
		s0   = {x15[6:0], x15[31:7]} ^ {x15[17:0], x15[31:18]} ^ (x15 >> 3);
		s1   = {x2[16:0], x2[31:17]} ^ {x2[18:0], x2[31:19]} ^ (x2 >> 10);
		wt   = rcnt_q[5:4] == 2'd0 ? w_q[rcnt_q[3:0]]
			: s1 + w_q[4'(rcnt_q + 6'd9)] + s0 + w_q[rcnt_q[3:0]];
		big1 = {v_q[4][5:0], v_q[4][31:6]} ^ {v_q[4][10:0], v_q[4][31:11]}
			^ {v_q[4][24:0], v_q[4][31:25]};
		chs  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1   = v_q[7] + big1 + chs + round_k(rcnt_q) + wt;
		big0 = {v_q[0][1:0], v_q[0][31:2]} ^ {v_q[0][12:0], v_q[0][31:13]}
			^ {v_q[0][21:0], v_q[0][31:22]};
		mj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcnt_q <= '0;
			rcnt_q <= '0;
			len_q  <= '0;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= INIT_HASH[255 - 32*i -: 32];
				v_q[i] <= '0;
			end
		end else if (cmd.init) begin
			wcnt_q <= '0;
			rcnt_q <= '0;
			len_q  <= '0;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= INIT_HASH[255 - 32*i -: 32];
				v_q[i] <= '0;
			end
		end else begin
			if (cmd.add_len)
				len_q <= len_next;
			if (cmd.push)
				wcnt_q <= wcnt_q + 4'd1;
			if (cmd.start)
				for (int i = 0; i < 8; i++)
					v_q[i] <= h_q[i];
			if (cmd.round) begin
				rcnt_q <= rcnt_q + 6'd1;
				v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
				v_q[4] <= v_q[3] + t1;
				v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
				v_q[0] <= t1 + big0 + mj;
			end
			if (cmd.fold)
				for (int i = 0; i < 8; i++)
					h_q[i] <= h_q[i] + v_q[i];
		end
	end

	// window: no reset, each slot written before it is read
	always_ff @(posedge clk) begin
		if (cmd.push)
			w_q[wcnt_q] <= push_word;
		else if (cmd.round && rcnt_q[5:4] != 2'd0)
			w_q[rcnt_q[3:0]] <= wt;
	end

	assign stat.word_cnt  = wcnt_q;
	assign stat.round_cnt = rcnt_q;
	assign digest_out     = h_q[emit_idx];
endmodule

FILE: sv/sha_ctrl.sv
module sha_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        valid_bytes,
	input  logic              last,
	output logic              out_valid_q,
	input  logic              out_stall,
	output logic [2:0]        emit_idx_q,
	output logic [2:0]        part_q,
	output sha_pkg::dp_cmd_t  cmd,
	input  sha_pkg::dp_stat_t stat
);
	import sha_pkg::*;

	state_t state_q, state_d;
	logic   last_q, full_q;
	logic   pad_done_q;
	logic   spill_q;
	logic   len_in_q;
	logic   acc;
	logic [2:0] cnt;

	assign cnt = (!last || valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
	assign in_stall = (state_q != ST_IDLE);
	assign acc = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			last_q      <= 1'b0;
			full_q      <= 1'b0;
			pad_done_q  <= 1'b0;
			spill_q     <= 1'b0;
			part_q      <= '0;
			emit_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc) begin
				last_q     <= last;
				full_q     <= (cnt == 3'd4);
				// a full word leaves no message bytes in the marker word
				part_q     <= (cnt == 3'd4) ? 3'd0 : cnt;
				pad_done_q <= 1'b0;
			end
			if (state_q == ST_PAD)
				pad_done_q <= 1'b1;
			// marker in slot 14 or 15: push the length in the next block
			if (acc || state_q == ST_FOLD)
				spill_q <= 1'b0;
			else if (cmd.push && cmd.push_sel == SEL_PART && stat.word_cnt >= 4'd14)
				spill_q <= 1'b1;
			if (state_q == ST_FOLD && state_d == ST_EMIT) begin
				out_valid_q <= 1'b1;
				emit_idx_q  <= '0;
			end else if (out_valid_q && !out_stall) begin
				emit_idx_q <= emit_idx_q + 3'd1;
				if (emit_idx_q == 3'd7)
					out_valid_q <= 1'b0;
			end
		end
	end

	// pad sequence: (data word if full) marker word, zeros to 14, two length words
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					cmd.add_len   = 1'b1;
					cmd.add_bytes = cnt;
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.push = 1'b1;
				cmd.push_sel = (last_q && !full_q) ? SEL_PART : SEL_DATA;
				if (stat.word_cnt == 4'd15)
					state_d = ST_ROUND;
				else if (last_q)
					state_d = ST_PAD;
				else
					state_d = ST_IDLE;
				cmd.start = (stat.word_cnt == 4'd15);
			end
			ST_PAD: begin
				cmd.push = 1'b1;
				if (full_q && !pad_done_q)
					cmd.push_sel = SEL_PART;
				else if (stat.word_cnt >= 4'd14 && !spill_q)
					cmd.push_sel = SEL_LEN;
				else
					cmd.push_sel = SEL_ZERO;
				cmd.start = (stat.word_cnt == 4'd15);
				if (stat.word_cnt == 4'd15)
					state_d = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				if (stat.round_cnt == 6'd63)
					state_d = ST_FOLD;
			end
			ST_FOLD: begin
				cmd.fold = 1'b1;
				if (last_q && (pad_done_q || !full_q) && stat.word_cnt == 4'd0
					&& len_in_q)
					state_d = ST_EMIT;
				else if (last_q)
					state_d = ST_PAD;
				else
					state_d = ST_IDLE;
			end
			ST_EMIT: begin
				if (out_valid_q && !out_stall && emit_idx_q == 3'd7) begin
					cmd.init = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// length written once the block just compressed held the length words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			len_in_q <= 1'b0;
		else if (cmd.init || acc)
			len_in_q <= 1'b0;
		else if (cmd.push && cmd.push_sel == SEL_LEN)
			len_in_q <= 1'b1;
	end
endmodule

FILE: sv/sha256_hash_engine_unit.sv
// channel | valid   | stall     | payload
// in      | valid   | stall     | data_word, valid_bytes, last
// out     | dvalid  | dstall    | digest_word, word_index, last_word
// A non-last word is taken in IDLE and pushed in LOAD; when it completes a 16-word block, ROUND and FOLD follow.
// A last word adds padding pushes (one per cycle) and one or two compressions;
// the compression datapath computes one round per cycle.
// Digest words leave one per cycle while dstall is low; input is held off until all eight are taken.
// arst_n clears control state and loads the initial hash.
module sha256_hash_engine_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        stall,
	input  logic [31:0] data_word,
	input  logic [2:0]  valid_bytes,
	input  logic        last,
	output logic        dvalid,
	input  logic        dstall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	import sha_pkg::*;

	dp_cmd_t    cmd;
	dp_stat_t   stat;
	logic [2:0] idx, part;
	logic [31:0] data_q;

	// hold the word while the controller works on it
	always_ff @(posedge clk)
		if (valid && !stall)
			data_q <= data_word;

	sha_ctrl u_ctrl (
		.clk, .arst_n, .in_valid(valid), .in_stall(stall), .valid_bytes, .last,
		.out_valid_q(dvalid), .out_stall(dstall), .emit_idx_q(idx), .part_q(part),
		.cmd, .stat
	);

	sha_dp u_dp (
		.clk, .arst_n, .cmd, .stat, .data_word(data_q), .part_bytes(part),
		.emit_idx(idx), .digest_out(digest_word)
	);

	assign word_index = idx;
	assign last_word  = (idx == 3'd7);
endmodule

FILE: sv/sha_chk.sv
module sha_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       valid,
	input logic       stall,
	input logic       dvalid,
	input logic       dstall,
	input logic [2:0] word_index,
	input logic       last_word
);
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		dvalid |-> (last_word == (word_index == 3'd7))) else $error("last_word");
	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		dvalid && !dstall && !last_word |=> dvalid && word_index == $past(word_index) + 3'd1)
		else $error("index order");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		dvalid |-> stall) else $error("input taken during output");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dvalid && dstall |=> dvalid && $stable(word_index)) else $error("hold");
endmodule

bind sha256_hash_engine_unit sha_chk u_chk (
	.clk, .arst_n, .valid, .stall, .dvalid, .dstall, .word_index, .last_word
);

FILE: verif/sha256_hash_engine_unit_tb.sv
module sha256_hash_engine_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} digest_t;

	// Streaming SHA-256 predictor and queue of expected digest words.
	class digest_board;
		logic [31:0] hval [8];
		logic [31:0] blk [16];
		int unsigned blk_cnt;
		logic [63:0] msg_bits;
		digest_t pending [$];
		int errors;

		function new();
			errors = 0;
			restart();
		endfunction

		function void restart();
			for (int i = 0; i < 8; i++) hval[i] = sha_pkg::INIT_HASH[255 - 32*i -: 32];
			blk_cnt = 0;
			msg_bits = '0;
		endfunction

		function logic [31:0] rotr(logic [31:0] v, int n);
			return (v >> n) | (v << (32 - n));
		endfunction

		function void compress();
			logic [31:0] v [8];
			logic [31:0] w [64];
			logic [31:0] t1, t2;
			for (int i = 0; i < 16; i++) w[i] = blk[i];
			for (int r = 16; r < 64; r++)
				w[r] = (rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10)) + w[r-7]
					+ (rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3)) + w[r-16];
			for (int i = 0; i < 8; i++) v[i] = hval[i];
			for (int r = 0; r < 64; r++) begin
				t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
					+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::round_k(r[5:0]) + w[r];
				t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
					+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
				v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
				v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
			end
			for (int i = 0; i < 8; i++) hval[i] += v[i];
		endfunction

		function void push(logic [31:0] w);
			blk[blk_cnt] = w;
			blk_cnt = (blk_cnt + 1) % 16;
			if (blk_cnt == 0) compress();
		endfunction

		function void note_word(logic [31:0] data, logic [2:0] nbytes, logic lst);
			int unsigned cnt;
			logic [31:0] keep;
			digest_t d;
			cnt = (!lst || nbytes > 4) ? 4 : nbytes;
			msg_bits += 64'(cnt * 8);
			if (!lst) begin
				push(data);
				return;
			end
			if (cnt == 4) begin
				push(data);
				push(sha_pkg::PAD_WORD);
			end else begin
				keep = (cnt == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8*cnt));
				push((data & keep) | (sha_pkg::PAD_WORD >> (8*cnt)));
			end
			while (blk_cnt != 14) push(32'h0);
			push(msg_bits[63:32]);
			push(msg_bits[31:0]);
			for (int i = 0; i < 8; i++) begin
				d.digest_word = hval[i];
				d.word_index = 3'(i);
				d.last_word = (i == 7);
				pending = {pending, d};
			end
			restart();
		endfunction

		task check_digest(digest_t got);
			digest_t exp_d;
			if (pending.size() == 0) begin
				report("digest word with nothing pending", got, got);
				return;
			end
			exp_d = pending.pop_front();
			if (got !== exp_d) report("digest word mismatch", got, exp_d);
		endtask

		task report(string what, digest_t got, digest_t want);
			$display("ERROR %s: got %h/%0d/%0b want %h/%0d/%0b", what, got.digest_word,
				got.word_index, got.last_word, want.digest_word, want.word_index,
				want.last_word);
			errors++;
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        valid;
	logic        stall;
	logic [31:0] data_word;
	logic [2:0]  valid_bytes;
	logic        last;
	logic        dvalid;
	logic        dstall;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	digest_board board;
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_off;
	int unsigned cycles;

	sha256_hash_engine_unit dut (
		.clk(clk), .arst_n(arst_n), .valid(valid), .stall(stall),
		.data_word(data_word), .valid_bytes(valid_bytes), .last(last),
		.dvalid(dvalid), .dstall(dstall), .digest_word(digest_word),
		.word_index(word_index), .last_word(last_word)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Receiver: random stall, or a long hold-off when asked.
	always @(posedge clk) begin
		if (dvalid && !dstall && arst_n) board.check_digest({digest_word, word_index, last_word});
		dstall <= hold_off || ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 2_000_000) begin
			$display("sha256_hash_engine_unit test failed");
			$finish;
		end
	end

	// Offer one transaction and hold it until accepted; valid drops only when idling.
	task automatic send_word(logic [31:0] d, logic [2:0] nb, logic lst);
		while ($urandom_range(99) < send_idle_pct) begin
			valid <= 1'b0;
			@(posedge clk);
		end
		valid <= 1'b1;
		data_word <= d;
		valid_bytes <= nb;
		last <= lst;
		@(posedge clk);
		while (stall) @(posedge clk);
		board.note_word(d, nb, lst);
	endtask

	task automatic send_message(int unsigned nwords);
		for (int i = 1; i < nwords; i++) send_word($urandom(), 3'($urandom_range(7)), 1'b0);
		send_word($urandom(), 3'($urandom_range(7)), 1'b1);
	endtask

	task automatic random_phase(int unsigned nitems);
		int unsigned done_items;
		int unsigned n;
		done_items = 0;
		while (done_items < nitems) begin
			// mostly short messages, now and then one crossing block boundaries
			n = ($urandom_range(9) == 0) ? $urandom_range(40, 14) : $urandom_range(16, 1);
			send_message(n);
			done_items += n;
		end
	endtask

	initial begin
		board = new();
		valid = 1'b0;
		data_word = '0;
		valid_bytes = '0;
		last = 1'b0;
		dstall = 1'b0;
		hold_off = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		cycles = 0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty message, every partial count, overlong counts, field extremes
		send_word(32'hffff_ffff, 3'd0, 1'b1);
		for (int nb = 1; nb < 8; nb++) send_word(32'hffff_ffff, 3'(nb), 1'b1);
		send_word(32'h0, 3'd4, 1'b1);
		send_word(32'h6162_6300, 3'd3, 1'b1);
		send_word(32'hffff_ffff, 3'd0, 1'b0);
		send_word(32'h0000_0000, 3'd7, 1'b1);
		// 13, 14 and 16 words: padding spills into a second block or not
		send_message(13);
		send_message(14);
		send_message(16);

		send_idle_pct = 0;  recv_stall_pct = 0;  random_phase(110);
		send_idle_pct = 47; recv_stall_pct = 0;  random_phase(110);
		send_idle_pct = 0;  recv_stall_pct = 47; random_phase(110);
		send_idle_pct = 6;  recv_stall_pct = 6;  random_phase(60);

		// long receiver hold-off while the sender keeps offering
		fork
			begin
				hold_off = 1'b1;
				repeat (600) @(posedge clk);
				hold_off = 1'b0;
			end
			begin
				send_idle_pct = 0;
				for (int m = 0; m < 4; m++) send_message(3);
				valid <= 1'b0;
			end
		join

		while (board.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("sha256_hash_engine_unit test passed");
		else
			$display("sha256_hash_engine_unit test failed");
		$finish;
	end
endmodule

FILE: sha256_hash_engine_unit.f
sv/sha_pkg.sv
sv/sha_dp.sv
sv/sha_ctrl.sv
sv/sha256_hash_engine_unit.sv
sv/sha_chk.sv
verif/sha256_hash_engine_unit_tb.sv
